### rtl/tld_pkg.sv
// Shared types and constants of the terminal input line discipline.
package tld_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = 6;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_FLAGS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_FLAGS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_KILL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EOL_CHARS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EOF_CHAR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_CHARS = 3'd5;

    localparam logic [3:0]  RST_INPUT_FLAGS  = 4'd0;
    localparam logic [5:0]  RST_LOCAL_FLAGS  = 6'd0;
    localparam logic [15:0] RST_ERASE_KILL   = 16'd5503;
    localparam logic [15:0] RST_EOL_CHARS    = 16'd0;
    localparam logic [7:0]  RST_EOF_CHAR     = 8'd4;
    localparam logic [15:0] RST_SIGNAL_CHARS = 16'd7171;

    localparam logic [7:0] STRIP_MASK = 8'h7F;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_SP      = 8'h20;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_C       = 8'h43;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;

    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_INTR = 2'd1;
    localparam logic [1:0] SIG_QUIT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP_RD,
        ST_POP_UPD,
        ST_ERASE_RD,
        ST_ERASE_CHK,
        ST_BSB,
        ST_PUSH,
        ST_FINAL
    } tld_state_t;

    typedef struct packed {
        logic load;
        logic rd_head;
        logic rd_tail;
        logic pop_commit;
        logic erase_commit;
        logic push;
        logic emit_bsb;
        logic emit_final;
    } tld_cmd_t;

    typedef struct packed {
        logic is_pop;
        logic fill_zero;
        logic ignore_cr;
        logic is_erase;
        logic is_kill;
        logic is_signal;
        logic rd_line_end;
        logic out_free;
    } tld_status_t;

endpackage

### rtl/tld_ctrl.sv
// Sequencing state machine of the terminal input line discipline.
module tld_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  tld_pkg::tld_status_t status,
    output tld_pkg::tld_cmd_t    cmd
);
    import tld_pkg::*;

    tld_state_t state_reg;
    tld_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.is_pop) begin
                    state_next = status.fill_zero ? ST_FINAL : ST_POP_RD;
                end else if (status.ignore_cr) begin
                    state_next = ST_FINAL;
                end else if (status.is_erase || status.is_kill) begin
                    state_next = status.fill_zero ? ST_FINAL : ST_ERASE_RD;
                end else if (status.is_signal) begin
                    state_next = ST_FINAL;
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_POP_RD:    state_next = ST_POP_UPD;
            ST_POP_UPD:   state_next = ST_FINAL;
            ST_ERASE_RD:  state_next = ST_ERASE_CHK;
            ST_ERASE_CHK: begin
                state_next = status.rd_line_end ? ST_FINAL : ST_BSB;
            end
            ST_BSB: begin
                if (status.out_free) begin
                    if (status.is_kill && !status.fill_zero) begin
                        state_next = ST_ERASE_RD;
                    end else begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_PUSH:      state_next = ST_FINAL;
            ST_FINAL: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_POP_RD:    cmd.rd_head = 1'b1;
            ST_POP_UPD:   cmd.pop_commit = 1'b1;
            ST_ERASE_RD:  cmd.rd_tail = 1'b1;
            ST_ERASE_CHK: cmd.erase_commit = !status.rd_line_end;
            ST_BSB:       cmd.emit_bsb = status.out_free;
            ST_PUSH:      cmd.push = 1'b1;
            ST_FINAL:     cmd.emit_final = status.out_free;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/tld_datapath.sv
// Configuration, receive queue, character decode and result register.
module tld_datapath #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [tld_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tld_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [7:0]                          s_tdata,
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tld_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [tld_pkg::OUT_USER_W-1:0]      m_tuser,
    output logic                                m_tlast,
    input  tld_pkg::tld_cmd_t                   cmd,
    output tld_pkg::tld_status_t                status
);
    import tld_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int SUM_W = CNT_W + 1;

    logic [3:0]  iflags_reg;
    logic [5:0]  lflags_reg;
    logic [15:0] ek_reg;
    logic [15:0] eol_reg;
    logic [7:0]  eof_reg;
    logic [15:0] sigc_reg;

    logic        cmd_reg;
    logic [7:0]  ch_reg;
    logic        ign_reg;
    logic        rv_reg;

    logic [IDX_W-1:0] head_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] lines_reg;

    logic [7:0] mem [QUEUE_DEPTH];
    logic [7:0] rd_data_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_USER_W-1:0] out_user_reg;
    logic                  out_last_reg;

    logic canon, echo_on, echoe, echok, echonl, sig_en;
    logic is_erase, is_kill, is_intr, is_quit, eot, queue_full;
    logic [7:0] ch_map;
    logic       ign_map;
    logic [SUM_W-1:0] tail_sum, last_sum;
    logic [IDX_W-1:0] tail_idx, last_idx, rd_addr;

    logic [1:0] fin_cnt, fin_sig;
    logic [7:0] fin_e1, fin_e2, fin_e3, fin_rb;
    logic [1:0] res_cnt, res_sig;
    logic [7:0] res_e1, res_e2, res_e3, res_rb;
    logic       res_rv;

    function automatic logic line_end(input logic [7:0] b, input logic [15:0] eol,
                                      input logic [7:0] eof);
        line_end = (b == CH_NL) || (b == eol[7:0]) || (b == eol[15:8]) || (b == eof);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iflags_reg <= RST_INPUT_FLAGS;
            lflags_reg <= RST_LOCAL_FLAGS;
            ek_reg     <= RST_ERASE_KILL;
            eol_reg    <= RST_EOL_CHARS;
            eof_reg    <= RST_EOF_CHAR;
            sigc_reg   <= RST_SIGNAL_CHARS;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_INPUT_FLAGS:  iflags_reg <= cfg_data[3:0];
                CFG_LOCAL_FLAGS:  lflags_reg <= cfg_data[5:0];
                CFG_ERASE_KILL:   ek_reg     <= cfg_data;
                CFG_EOL_CHARS:    eol_reg    <= cfg_data;
                CFG_EOF_CHAR:     eof_reg    <= cfg_data[7:0];
                CFG_SIGNAL_CHARS: sigc_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // strip, then map newline and carriage return, or mark a carriage return as ignored
    always_comb begin
        ch_map  = iflags_reg[0] ? (s_tdata & STRIP_MASK) : s_tdata;
        ign_map = 1'b0;
        if (ch_map == CH_NL && iflags_reg[1]) begin
            ch_map = CH_CR;
        end else if (ch_map == CH_CR && iflags_reg[2]) begin
            ch_map = CH_NL;
        end else if (ch_map == CH_CR && iflags_reg[3]) begin
            ign_map = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= s_tuser;
            ch_reg  <= ch_map;
            ign_reg <= ign_map;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg <= 1'b0;
        end else if (cmd.load) begin
            rv_reg <= 1'b0;
        end else if (cmd.pop_commit) begin
            rv_reg <= 1'b1;
        end
    end

    assign canon   = lflags_reg[0];
    assign echo_on = lflags_reg[1];
    assign echoe   = lflags_reg[2];
    assign echok   = lflags_reg[3];
    assign echonl  = lflags_reg[4];
    assign sig_en  = lflags_reg[5];

    assign eot      = canon && line_end(ch_reg, eol_reg, eof_reg);
    assign is_erase = canon && (ch_reg == ek_reg[7:0]);
    assign is_kill  = canon && !is_erase && (ch_reg == ek_reg[15:8]);
    assign is_intr  = sig_en && (ch_reg == sigc_reg[7:0]);
    assign is_quit  = sig_en && !is_intr && (ch_reg == sigc_reg[15:8]);

    assign queue_full = (fill_reg >= CNT_W'(QUEUE_DEPTH));

    // wrap head + fill and head + fill - 1 into the ring
    always_comb begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(fill_reg);
        last_sum = tail_sum - SUM_W'(1);
        if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
        end
        if (last_sum >= SUM_W'(QUEUE_DEPTH)) begin
            last_sum = last_sum - SUM_W'(QUEUE_DEPTH);
        end
        tail_idx = tail_sum[IDX_W-1:0];
        last_idx = last_sum[IDX_W-1:0];
        rd_addr  = cmd.rd_tail ? last_idx : head_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.push && !queue_full) begin
            mem[tail_idx] <= ch_reg;
        end
        if (cmd.rd_head || cmd.rd_tail) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            fill_reg  <= '0;
            lines_reg <= '0;
        end else if (cmd.pop_commit) begin
            head_reg <= (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
            fill_reg <= fill_reg - CNT_W'(1);
            if (line_end(rd_data_reg, eol_reg, eof_reg) && lines_reg != '0) begin
                lines_reg <= lines_reg - CNT_W'(1);
            end
        end else if (cmd.erase_commit) begin
            fill_reg <= fill_reg - CNT_W'(1);
        end else if (cmd.push && !queue_full) begin
            fill_reg <= fill_reg + CNT_W'(1);
            if (eot && lines_reg < CNT_W'(QUEUE_DEPTH)) begin
                lines_reg <= lines_reg + CNT_W'(1);
            end
        end
    end

    // final word of an item
    always_comb begin
        fin_cnt = 2'd0;
        fin_sig = SIG_NONE;
        fin_e1  = '0;
        fin_e2  = '0;
        fin_e3  = '0;
        fin_rb  = '0;
        if (cmd_reg) begin
            fin_rb = rv_reg ? rd_data_reg : 8'd0;
        end else if (ign_reg) begin
            fin_cnt = 2'd0;
        end else if (is_erase) begin
            if (!echoe && echo_on) begin
                fin_cnt = 2'd1;
                fin_e1  = ch_reg;
            end
        end else if (is_kill) begin
            if (!echoe && echo_on) begin
                fin_cnt = 2'd1;
                fin_e1  = ch_reg;
                if (echok) begin
                    fin_cnt = 2'd2;
                    fin_e2  = CH_NL;
                end
            end
        end else if (is_intr) begin
            fin_sig = SIG_INTR;
            if (echo_on) begin
                fin_cnt = 2'd2;
                fin_e1  = CH_CARET;
                fin_e2  = CH_C;
            end
        end else if (is_quit) begin
            fin_sig = SIG_QUIT;
            if (echo_on) begin
                fin_cnt = 2'd2;
                fin_e1  = CH_CARET;
                fin_e2  = CH_BSLASH;
            end
        end else if (echo_on) begin
            fin_cnt = 2'd1;
            fin_e1  = ch_reg;
        end else if (echonl && eot && ch_reg == CH_NL) begin
            fin_cnt = 2'd1;
            fin_e1  = CH_NL;
        end
    end

    always_comb begin
        if (cmd.emit_bsb) begin
            res_cnt = echo_on ? 2'd3 : 2'd0;
            res_e1  = echo_on ? CH_BS : 8'd0;
            res_e2  = echo_on ? CH_SP : 8'd0;
            res_e3  = echo_on ? CH_BS : 8'd0;
            res_sig = SIG_NONE;
            res_rb  = '0;
            res_rv  = 1'b0;
        end else begin
            res_cnt = fin_cnt;
            res_e1  = fin_e1;
            res_e2  = fin_e2;
            res_e3  = fin_e3;
            res_sig = fin_sig;
            res_rb  = fin_rb;
            res_rv  = cmd_reg && rv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_bsb || cmd.emit_final) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_bsb || cmd.emit_final) begin
            out_data_reg <= {2'b00, lines_reg, fill_reg, res_rb, res_e3, res_e2, res_e1,
                             res_cnt};
            out_user_reg <= {res_rv, res_sig};
            out_last_reg <= cmd.emit_final;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    assign status.is_pop      = cmd_reg;
    assign status.fill_zero   = (fill_reg == '0);
    assign status.ignore_cr   = ign_reg;
    assign status.is_erase    = is_erase;
    assign status.is_kill     = is_kill;
    assign status.is_signal   = is_intr || is_quit;
    assign status.rd_line_end = line_end(rd_data_reg, eol_reg, eof_reg);
    assign status.out_free    = !out_valid_reg || m_tready;

endmodule

### rtl/tty_line_discipline.sv
// Top level of the terminal input line discipline.
//
//  channel  direction  payload
//  s_*      in         tdata: rx_byte[7:0]; tuser: command[0]
//  m_*      out        tdata: echo_count, echo_first, echo_second, echo_third, read_byte,
//                      queued_count, line_count; tuser: signal_kind, read_valid; tlast
//  cfg_*    in         write enable, register index, 16-bit data
//
// One word at a time: an ignored CR, a signal, or a pop, erase or kill on an empty queue goes
// straight to its result; a queued byte is first written; a pop first does a registered queue
// read. Erase removes one byte and kill repeats until the queue is empty; a line end stops both.
// A new word is taken while the last result still waits in the output register.
// Reset clears configuration, queue pointers and line count; queue contents are not cleared.
// A stalled output holds the sequencer in its emit state.
module tty_line_discipline #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [tld_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tld_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // rx_byte[7:0]
    input  logic                                s_tuser,  // command[0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // echo_count[1:0] echo_first[9:2] echo_second[17:10] echo_third[25:18]
    // read_byte[33:26] queued_count[39:34] line_count[45:40]
    output logic [tld_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [tld_pkg::OUT_USER_W-1:0]      m_tuser,  // signal_kind[1:0] read_valid[2]
    output logic                                m_tlast
);
    import tld_pkg::*;

    tld_cmd_t    cmd;
    tld_status_t status;

    tld_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tld_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
